// ===== hdl/mpfa_pkg.sv =====
// Shared types and operation codes of the Montgomery prime field ALU.
`default_nettype none
package mpfa_pkg;

  // Operation codes carried in the kind field
  localparam logic [3:0] KIND_ADD   = 4'd0;
  localparam logic [3:0] KIND_SUB   = 4'd1;
  localparam logic [3:0] KIND_MUL   = 4'd2;
  localparam logic [3:0] KIND_NEG   = 4'd3;
  localparam logic [3:0] KIND_INV   = 4'd4;
  localparam logic [3:0] KIND_DIV   = 4'd5;
  localparam logic [3:0] KIND_TOM   = 4'd6;
  localparam logic [3:0] KIND_FROM  = 4'd7;
  localparam logic [3:0] KIND_RATIO = 4'd8;

  // Configuration register indexes
  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_NEGINV  = 2'd1;
  localparam logic [1:0] REG_RSQ     = 2'd2;

  localparam logic [62:0] MODULUS_RST = 63'd3;
  localparam logic [63:0] NEGINV_RST  = 64'h5555555555555555;
  localparam logic [62:0] RSQ_RST     = 63'd1;

  typedef struct packed {
    logic [3:0]         kind;
    logic [62:0]        op_a;
    logic [62:0]        op_b;
    logic signed [63:0] signed_num;
    logic signed [63:0] signed_den;
  } in_beat_t;

  typedef struct packed {
    logic [62:0] value;
    logic        singular;
  } out_beat_t;

endpackage
`default_nettype wire

// ===== hdl/montgomery_prime_field_alu.sv =====
// Top level of the Montgomery prime field ALU: sequencer with bit-serial units.
//
//  channel | direction | handshake            | beat
//  in_     | input     | in_valid / in_stall   | in_beat_t (kind, op_a, op_b, num, den)
//  out_    | output    | out_valid / out_stall | out_beat_t (value, singular)
//  cfg_    | input     | cfg_we                | cfg_index selects, cfg_wdata 64 bits
//
// One item at a time. Add, sub, neg and unused kinds pass through S_DISP, S_SIMPLE and S_FIN.
// A Montgomery multiply runs the shift-add multiplier three times.
// Inversion first reduces out of Montgomery form, then runs extended Euclid with one
// division per quotient step plus one for the first residue, then a Montgomery multiply
// by the R^2 register for the conversion.
// Reset restores the register defaults and clears the singular flag; no clearing pass.
// A result waiting on out_stall holds its register; a new beat is still taken meanwhile.
`default_nettype none
module montgomery_prime_field_alu import mpfa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_beat_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  localparam logic [4:0] S_IDLE = 5'd0,  S_DISP = 5'd1,  S_SIMPLE = 5'd2, S_FIN = 5'd3,
                         S_MUL  = 5'd4,  S_MTM  = 5'd5,  S_RED0 = 5'd6,   S_RED1 = 5'd7,
                         S_RED2 = 5'd8,  S_RED3 = 5'd9,  S_DIV  = 5'd10,  S_INV0 = 5'd11,
                         S_INV1 = 5'd12, S_INV2 = 5'd13, S_INV3 = 5'd14,  S_INV4 = 5'd15,
                         S_FL0  = 5'd16, S_FL1  = 5'd17, S_K4A  = 5'd18,  S_K4B  = 5'd19,
                         S_K5C  = 5'd20, S_R1   = 5'd21, S_R2   = 5'd22,  S_R3   = 5'd23,
                         S_R4   = 5'd24, S_PM   = 5'd25;

  logic [4:0]  state_r, state_nxt;
  logic [4:0]  mul_ret_r, mul_ret_nxt, red_ret_r, red_ret_nxt, div_ret_r, div_ret_nxt;
  logic [4:0]  inv_ret_r, inv_ret_nxt, fl_ret_r, fl_ret_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        ph_r, ph_nxt;

  logic [62:0] p_r, p_nxt, r2_r, r2_nxt;
  logic [63:0] ninv_r, ninv_nxt;
  logic        sing_r, sing_nxt;

  logic [3:0]  kind_r, kind_nxt;
  logic [62:0] a_r, a_nxt, b_r, b_nxt;
  logic [63:0] num_r, num_nxt, den_r, den_nxt;

  logic [63:0] mx_r, mx_nxt, my_r, my_nxt, phi_r, phi_nxt, plo_r, plo_nxt;
  logic [63:0] thi_r, thi_nxt, tlo_r, tlo_nxt, tr_r, tr_nxt, val_r, val_nxt;
  logic [63:0] dd_r, dd_nxt, dv_r, dv_nxt, rem_r, rem_nxt, qn_r, qn_nxt;
  logic [63:0] re_r, re_nxt, nre_r, nre_nxt, te_r, te_nxt, nte_r, nte_nxt;
  logic [63:0] inv_in_r, inv_in_nxt, inv_res_r, inv_res_nxt;
  logic [63:0] fl_in_r, fl_in_nxt, fl_res_r, fl_res_nxt;
  logic        fl_neg_r, fl_neg_nxt;
  logic [63:0] n_r, n_nxt, pm_acc_r, pm_acc_nxt, pm_b_r, pm_b_nxt;

  logic        out_valid_r, out_valid_nxt;
  out_beat_t   out_data_r, out_data_nxt;

  // Unit call requests
  logic        mm_go, mul_go, div_go;
  logic [63:0] mm_x, mm_y, mul_x, mul_y, div_a, div_b;
  logic [4:0]  mm_ret, mul_rt, div_rt;

  logic [63:0] p64, r2_64, a64, b64, src64;
  logic [64:0] msum, rs, rsum;
  logic        ge;
  logic [63:0] s64, sh64;

  assign p64   = {1'b0, p_r};
  assign r2_64 = {1'b0, r2_r};
  assign a64   = {1'b0, a_r};
  assign b64   = {1'b0, b_r};
  assign src64 = (kind_r == KIND_DIV) ? b64 : a64;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;   mul_ret_nxt = mul_ret_r; red_ret_nxt = red_ret_r;
    div_ret_nxt = div_ret_r; inv_ret_nxt = inv_ret_r; fl_ret_nxt = fl_ret_r;
    cnt_nxt = cnt_r; ph_nxt = ph_r;
    p_nxt = p_r; r2_nxt = r2_r; ninv_nxt = ninv_r; sing_nxt = sing_r;
    kind_nxt = kind_r; a_nxt = a_r; b_nxt = b_r; num_nxt = num_r; den_nxt = den_r;
    mx_nxt = mx_r; my_nxt = my_r; phi_nxt = phi_r; plo_nxt = plo_r;
    thi_nxt = thi_r; tlo_nxt = tlo_r; tr_nxt = tr_r; val_nxt = val_r;
    dd_nxt = dd_r; dv_nxt = dv_r; rem_nxt = rem_r; qn_nxt = qn_r;
    re_nxt = re_r; nre_nxt = nre_r; te_nxt = te_r; nte_nxt = nte_r;
    inv_in_nxt = inv_in_r; inv_res_nxt = inv_res_r;
    fl_in_nxt = fl_in_r; fl_res_nxt = fl_res_r; fl_neg_nxt = fl_neg_r;
    n_nxt = n_r; pm_acc_nxt = pm_acc_r; pm_b_nxt = pm_b_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt = out_data_r;
    mm_go = 1'b0; mm_x = '0; mm_y = '0; mm_ret = S_FIN;
    mul_go = 1'b0; mul_x = '0; mul_y = '0; mul_rt = S_FIN;
    div_go = 1'b0; div_a = '0; div_b = '0; div_rt = S_FIN;
    msum = '0; rs = '0; rsum = '0; ge = 1'b0; s64 = '0; sh64 = '0;

    // Configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS: begin p_nxt = cfg_wdata[62:0]; sing_nxt = 1'b0; end
        REG_NEGINV:  ninv_nxt = cfg_wdata;
        REG_RSQ:     r2_nxt = cfg_wdata[62:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_data.kind; a_nxt = in_data.op_a; b_nxt = in_data.op_b;
          num_nxt = in_data.signed_num; den_nxt = in_data.signed_den;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (kind_r) inside
          KIND_MUL: begin mm_go = 1'b1; mm_x = a64; mm_y = b64; mm_ret = S_FIN; end
          KIND_INV, KIND_DIV: begin
            if (src64 == '0) begin
              sing_nxt = 1'b1; val_nxt = '0;
              state_nxt = (kind_r == KIND_DIV) ? S_K5C : S_FIN;
            end else begin
              thi_nxt = '0; tlo_nxt = src64; red_ret_nxt = S_K4A; state_nxt = S_RED0;
            end
          end
          KIND_TOM: begin mm_go = 1'b1; mm_x = a64; mm_y = r2_64; mm_ret = S_FIN; end
          KIND_FROM: begin
            thi_nxt = '0; tlo_nxt = a64; red_ret_nxt = S_FIN; state_nxt = S_RED0;
          end
          KIND_RATIO: begin fl_in_nxt = num_r; fl_ret_nxt = S_R1; state_nxt = S_FL0; end
          default: state_nxt = S_SIMPLE;
        endcase
      end
      // Add, subtract, negate in one step; other kinds give zero
      S_SIMPLE: begin
        case (kind_r)
          KIND_ADD: begin
            s64 = a64 + b64;
            val_nxt = (s64 >= p64) ? s64 - p64 : s64;
          end
          KIND_SUB: val_nxt = (a64 >= b64) ? a64 - b64 : a64 + p64 - b64;
          KIND_NEG: val_nxt = (a64 != '0) ? p64 - a64 : '0;
          default:  val_nxt = '0;
        endcase
        state_nxt = S_FIN;
      end
      // Hand the result over once the output register is free
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.value = val_r[62:0];
          out_data_nxt.singular = sing_r;
          state_nxt = S_IDLE;
        end
      end
      // Shift-add multiplier: one multiplier bit a cycle, LSB first
      S_MUL: begin
        msum = {1'b0, phi_r} + (my_r[0] ? {1'b0, mx_r} : 65'd0);
        phi_nxt = msum[64:1];
        plo_nxt = {msum[0], plo_r[63:1]};
        my_nxt = {1'b0, my_r[63:1]};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) state_nxt = mul_ret_r;
      end
      S_MTM: begin thi_nxt = phi_r; tlo_nxt = plo_r; state_nxt = S_RED0; end
      // Montgomery reduction
      S_RED0: begin mul_go = 1'b1; mul_x = tlo_r; mul_y = ninv_r; mul_rt = S_RED1; end
      S_RED1: begin mul_go = 1'b1; mul_x = plo_r; mul_y = p64; mul_rt = S_RED2; end
      S_RED2: begin
        rsum = {1'b0, tlo_r} + {1'b0, plo_r};
        tr_nxt = thi_r + phi_r + {63'd0, rsum[64]};
        state_nxt = S_RED3;
      end
      S_RED3: begin
        val_nxt = (tr_r >= p64) ? tr_r - p64 : tr_r;
        state_nxt = red_ret_r;
      end
      // Restoring division, quotient folded into q * nt on the fly
      S_DIV: begin
        rs = {rem_r, dd_r[63]};
        ge = (rs >= {1'b0, dv_r});
        rem_nxt = ge ? 64'(rs - {1'b0, dv_r}) : rs[63:0];
        dd_nxt = {dd_r[62:0], 1'b0};
        qn_nxt = {qn_r[62:0], 1'b0} + (ge ? nte_r : 64'd0);
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) state_nxt = div_ret_r;
      end
      // Extended Euclid
      S_INV0: begin
        if (p64 == '0) begin
          inv_res_nxt = '0; state_nxt = inv_ret_r;
        end else begin
          div_go = 1'b1; div_a = inv_in_r; div_b = p64; div_rt = S_INV1;
        end
      end
      S_INV1: begin
        re_nxt = p64; nre_nxt = rem_r; te_nxt = '0; nte_nxt = 64'd1; state_nxt = S_INV2;
      end
      S_INV2: begin
        if (nre_r == '0) state_nxt = S_INV4;
        else begin div_go = 1'b1; div_a = re_r; div_b = nre_r; div_rt = S_INV3; end
      end
      S_INV3: begin
        te_nxt = nte_r; nte_nxt = te_r - qn_r; re_nxt = nre_r; nre_nxt = rem_r;
        state_nxt = S_INV2;
      end
      S_INV4: begin
        inv_res_nxt = te_r[63] ? te_r + p64 : te_r;
        state_nxt = inv_ret_r;
      end
      // Floor residue of a signed value
      S_FL0: begin
        if (p64 == '0) begin
          fl_res_nxt = '0; state_nxt = fl_ret_r;
        end else begin
          fl_neg_nxt = fl_in_r[63];
          div_go = 1'b1; div_a = fl_in_r[63] ? 64'd0 - fl_in_r : fl_in_r;
          div_b = p64; div_rt = S_FL1;
        end
      end
      S_FL1: begin
        fl_res_nxt = !fl_neg_r ? rem_r : ((rem_r == '0) ? '0 : p64 - rem_r);
        state_nxt = fl_ret_r;
      end
      // Inverse and divide
      S_K4A: begin inv_in_nxt = val_r; inv_ret_nxt = S_K4B; state_nxt = S_INV0; end
      S_K4B: begin
        mm_go = 1'b1; mm_x = inv_res_r; mm_y = r2_64;
        mm_ret = (kind_r == KIND_DIV) ? S_K5C : S_FIN;
      end
      S_K5C: begin mm_go = 1'b1; mm_x = a64; mm_y = val_r; mm_ret = S_FIN; end
      // Signed ratio
      S_R1: begin
        n_nxt = fl_res_r;
        if (den_r == 64'd1) begin
          mm_go = 1'b1; mm_x = fl_res_r; mm_y = r2_64; mm_ret = S_FIN;
        end else begin
          fl_in_nxt = den_r; fl_ret_nxt = S_R2; state_nxt = S_FL0;
        end
      end
      S_R2: begin
        if (fl_res_r == '0) begin
          sing_nxt = 1'b1; val_nxt = '0; state_nxt = S_FIN;
        end else begin
          inv_in_nxt = fl_res_r; inv_ret_nxt = S_R3; state_nxt = S_INV0;
        end
      end
      S_R3: begin
        pm_acc_nxt = '0; pm_b_nxt = inv_res_r; cnt_nxt = '0; ph_nxt = 1'b0;
        state_nxt = S_PM;
      end
      // Double-and-add modular multiply, MSB first, a doubling phase then an add phase per bit
      S_PM: begin
        if (!ph_r) begin
          sh64 = {pm_acc_r[62:0], 1'b0};
          pm_acc_nxt = (sh64 >= p64) ? sh64 - p64 : sh64;
          ph_nxt = 1'b1;
        end else begin
          if (pm_b_r[63]) begin
            s64 = pm_acc_r + n_r;
            pm_acc_nxt = (s64 >= p64) ? s64 - p64 : s64;
          end
          pm_b_nxt = {pm_b_r[62:0], 1'b0};
          ph_nxt = 1'b0;
          cnt_nxt = cnt_r + 6'd1;
          if (cnt_r == 6'd63) state_nxt = S_R4;
        end
      end
      S_R4: begin mm_go = 1'b1; mm_x = pm_acc_r; mm_y = r2_64; mm_ret = S_FIN; end
      default: state_nxt = S_IDLE;
    endcase

    // Launch requested units
    if (mm_go) begin
      mx_nxt = mm_x; my_nxt = mm_y; phi_nxt = '0; plo_nxt = '0; cnt_nxt = '0;
      mul_ret_nxt = S_MTM; red_ret_nxt = mm_ret; state_nxt = S_MUL;
    end
    if (mul_go) begin
      mx_nxt = mul_x; my_nxt = mul_y; phi_nxt = '0; plo_nxt = '0; cnt_nxt = '0;
      mul_ret_nxt = mul_rt; state_nxt = S_MUL;
    end
    if (div_go) begin
      dd_nxt = div_a; dv_nxt = div_b; rem_nxt = '0; qn_nxt = '0; cnt_nxt = '0;
      div_ret_nxt = div_rt; state_nxt = S_DIV;
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; mul_ret_r <= S_FIN; red_ret_r <= S_FIN; div_ret_r <= S_FIN;
      inv_ret_r <= S_FIN; fl_ret_r <= S_FIN; cnt_r <= '0; ph_r <= 1'b0;
      p_r <= MODULUS_RST; ninv_r <= NEGINV_RST; r2_r <= RSQ_RST; sing_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; mul_ret_r <= mul_ret_nxt; red_ret_r <= red_ret_nxt;
      div_ret_r <= div_ret_nxt; inv_ret_r <= inv_ret_nxt; fl_ret_r <= fl_ret_nxt;
      cnt_r <= cnt_nxt; ph_r <= ph_nxt;
      p_r <= p_nxt; ninv_r <= ninv_nxt; r2_r <= r2_nxt; sing_r <= sing_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt; a_r <= a_nxt; b_r <= b_nxt; num_r <= num_nxt; den_r <= den_nxt;
    mx_r <= mx_nxt; my_r <= my_nxt; phi_r <= phi_nxt; plo_r <= plo_nxt;
    thi_r <= thi_nxt; tlo_r <= tlo_nxt; tr_r <= tr_nxt; val_r <= val_nxt;
    dd_r <= dd_nxt; dv_r <= dv_nxt; rem_r <= rem_nxt; qn_r <= qn_nxt;
    re_r <= re_nxt; nre_r <= nre_nxt; te_r <= te_nxt; nte_r <= nte_nxt;
    inv_in_r <= inv_in_nxt; inv_res_r <= inv_res_nxt;
    fl_in_r <= fl_in_nxt; fl_res_r <= fl_res_nxt; fl_neg_r <= fl_neg_nxt;
    n_r <= n_nxt; pm_acc_r <= pm_acc_nxt; pm_b_r <= pm_b_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/mpfa_checker.sv =====
// Port-level checker for the Montgomery prime field ALU and its bind.
`default_nettype none
module mpfa_checker import mpfa_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire out_beat_t  out_data,
  input wire logic       cfg_we,
  input wire logic [1:0] cfg_index
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat dropped or changed");

  // Go busy after taking a beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while still idle after accept");

  // Raise a result only out of a busy cycle
  a_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  // Clear the singular flag on a modulus write, checked at a single later cycle
  a_flag_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == REG_MODULUS && !in_stall && !in_valid
      |=> ##3 !($rose(out_valid) && out_data.singular))
    else $error("singular flag survived a modulus write");

endmodule

bind montgomery_prime_field_alu mpfa_checker u_mpfa_checker (.*);
`default_nettype wire

// ===== bench/montgomery_prime_field_alu_tb.sv =====
// Testbench for the Montgomery prime field ALU: directed and random beats checked by a predictor.
`default_nettype none
module montgomery_prime_field_alu_tb;
  import mpfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallCap = 60000;
  localparam int unsigned HoldOff  = 400;
  localparam logic [63:0] PrimeTop = 64'd9223372036854775783;
  localparam logic [63:0] Mersenne = 64'd2305843009213693951;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [63:0] cfg_wdata;

  // Predictor state: field registers and the sticky singular flag
  logic [63:0] fld_p;
  logic [63:0] fld_ninv;
  logic [63:0] fld_rsq;
  logic        fld_sing;

  out_beat_t pending_q[$];
  int unsigned fails;
  int unsigned quiet_cycles;
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_req;

  montgomery_prime_field_alu DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Montgomery reduction of a 128-bit value, carry past 128 bits dropped
  function automatic logic [63:0] redc(logic [63:0] hi, logic [63:0] lo);
    logic [63:0] m;
    logic [127:0] sum;
    logic [63:0] t;
    m = lo * fld_ninv;
    sum = {hi, lo} + ({64'd0, m} * {64'd0, fld_p});
    t = sum[127:64];
    return (t >= fld_p) ? t - fld_p : t;
  endfunction

  function automatic logic [63:0] mont_mult(logic [63:0] a, logic [63:0] b);
    logic [127:0] pr;
    pr = {64'd0, a} * {64'd0, b};
    return redc(pr[127:64], pr[63:0]);
  endfunction

  // Extended Euclid with the cofactor wrapping modulo 2^64
  function automatic logic [63:0] euclid_inv(logic [63:0] a, logic [63:0] p);
    logic [63:0] r, nr, t, nt, q, tmp;
    if (p == 64'd0) return 64'd0;
    r = p;
    nr = a % p;
    t = 64'd0;
    nt = 64'd1;
    if (nr == 64'd0) return 64'd0;
    while (nr != 64'd0) begin
      q = r / nr;
      tmp = t - q * nt; t = nt; nt = tmp;
      tmp = r % nr; r = nr; nr = tmp;
    end
    if (t[63]) t = t + p;
    return t;
  endfunction

  function automatic logic [63:0] floor_res(logic [63:0] v, logic [63:0] p);
    logic [63:0] r;
    if (p == 64'd0) return 64'd0;
    if (!v[63]) return v % p;
    r = (64'd0 - v) % p;
    return (r == 64'd0) ? 64'd0 : p - r;
  endfunction

  function automatic logic [63:0] field_inv(logic [63:0] a);
    if (a == 64'd0) begin
      fld_sing = 1'b1;
      return 64'd0;
    end
    return mont_mult(euclid_inv(redc(64'd0, a), fld_p), fld_rsq);
  endfunction

  // Expected result of one beat; updates the singular flag
  function automatic out_beat_t field_predict(in_beat_t x);
    logic [63:0] a, b, s, v, n, d;
    logic [127:0] pr;
    out_beat_t y;
    a = {1'b0, x.op_a};
    b = {1'b0, x.op_b};
    v = 64'd0;
    case (x.kind)
      KIND_ADD: begin
        s = a + b;
        v = (s >= fld_p) ? s - fld_p : s;
      end
      KIND_SUB:   v = (a >= b) ? a - b : a + fld_p - b;
      KIND_MUL:   v = mont_mult(a, b);
      KIND_NEG:   v = (a != 64'd0) ? fld_p - a : 64'd0;
      KIND_INV:   v = field_inv(a);
      KIND_DIV:   v = mont_mult(a, field_inv(b));
      KIND_TOM:   v = mont_mult(a, fld_rsq);
      KIND_FROM:  v = redc(64'd0, a);
      KIND_RATIO: begin
        n = floor_res(x.signed_num, fld_p);
        if (x.signed_den == 64'sd1) begin
          v = mont_mult(n, fld_rsq);
        end else begin
          d = floor_res(x.signed_den, fld_p);
          if (d == 64'd0) begin
            fld_sing = 1'b1;
            v = 64'd0;
          end else begin
            pr = ({64'd0, n} * {64'd0, euclid_inv(d, fld_p)}) % {64'd0, fld_p};
            v = mont_mult(pr[63:0], fld_rsq);
          end
        end
      end
      default: v = 64'd0;
    endcase
    y.value = v[62:0];
    y.singular = fld_sing;
    return y;
  endfunction

  task automatic reg_write(logic [1:0] idx, logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MODULUS: begin
        fld_p = {1'b0, data[62:0]};
        fld_sing = 1'b0;
      end
      REG_NEGINV: fld_ninv = data;
      REG_RSQ:    fld_rsq = {1'b0, data[62:0]};
      default: ;
    endcase
  endtask

  // Load a consistent register set for modulus p
  task automatic set_field(logic [63:0] p);
    logic [63:0] inv;
    logic [128:0] big;
    inv = p;
    repeat (6) inv = inv * (64'd2 - p * inv);
    big = (129'd1 << 128) % {65'd0, p};
    reg_write(REG_MODULUS, p);
    reg_write(REG_NEGINV, 64'd0 - inv);
    reg_write(REG_RSQ, big[63:0]);
  endtask

  // Offer one beat, hold it until taken, then maybe idle
  task automatic send_item(in_beat_t x);
    in_data <= x;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(field_predict(x));
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [62:0] pick_res();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return 63'd0;
      1: return (fld_p != 64'd0) ? fld_p[62:0] - 63'd1 : 63'd0;
      2: return r[62:0];
      default: return (fld_p != 64'd0) ? 63'(r[62:0] % fld_p) : r[62:0];
    endcase
  endfunction

  function automatic logic [63:0] pick_signed();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return 64'd1;
      1: return 64'd0;
      2: return fld_p * 64'($urandom_range(1, 3));
      3: return 64'd0 - fld_p;
      4: return 64'(64'sd0 - 64'sd1 * $signed({32'd0, $urandom_range(1, 50)}));
      default: return r;
    endcase
  endfunction

  function automatic in_beat_t make_beat(logic [3:0] k, logic [62:0] a, logic [62:0] b,
                                         logic [63:0] n, logic [63:0] d);
    in_beat_t x;
    x.kind = k;
    x.op_a = a;
    x.op_b = b;
    x.signed_num = n;
    x.signed_den = d;
    return x;
  endfunction

  // Random beats, slow operations kept rarer than fast ones
  task automatic run_random(int unsigned count);
    int unsigned r;
    logic [3:0] k;
    logic [3:0] fast [6];
    fast = '{KIND_ADD, KIND_SUB, KIND_MUL, KIND_NEG, KIND_TOM, KIND_FROM};
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 8) k = KIND_INV;
      else if (r < 14) k = KIND_DIV;
      else if (r < 22) k = KIND_RATIO;
      else if (r < 26) k = 4'($urandom_range(9, 15));
      else k = fast[$urandom_range(0, 5)];
      send_item(make_beat(k, pick_res(), pick_res(), pick_signed(), pick_signed()));
    end
    drain();
  endtask

  task automatic test_reset_defaults();
    send_item(make_beat(KIND_ADD, 63'd2, 63'd2, 64'd0, 64'd0));
    send_item(make_beat(KIND_INV, 63'd0, 63'd0, 64'd0, 64'd0));
    send_item(make_beat(KIND_MUL, 63'd1, 63'd2, 64'd0, 64'd0));
    send_item(make_beat(4'd15, 63'd1, 63'd1, 64'd0, 64'd0));
    drain();
  endtask

  // Extremes of every field, every kind and the singular cases
  task automatic test_directed();
    logic [62:0] pm, ones;
    set_field(PrimeTop);
    pm = PrimeTop[62:0] - 63'd1;
    ones = '1;
    send_item(make_beat(KIND_ADD, pm, pm, 64'd0, 64'd0));
    send_item(make_beat(KIND_ADD, 63'd0, 63'd0, 64'd0, 64'd0));
    send_item(make_beat(KIND_SUB, 63'd0, pm, 64'd0, 64'd0));
    send_item(make_beat(KIND_SUB, pm, 63'd0, 64'd0, 64'd0));
    send_item(make_beat(KIND_MUL, pm, pm, 64'd0, 64'd0));
    send_item(make_beat(KIND_MUL, ones, ones, 64'd0, 64'd0));
    send_item(make_beat(KIND_NEG, 63'd0, 63'd0, 64'd0, 64'd0));
    send_item(make_beat(KIND_NEG, pm, 63'd0, 64'd0, 64'd0));
    send_item(make_beat(KIND_INV, 63'd12345, 63'd0, 64'd0, 64'd0));
    send_item(make_beat(KIND_INV, PrimeTop[62:0], 63'd0, 64'd0, 64'd0));
    send_item(make_beat(KIND_INV, 63'd0, 63'd0, 64'd0, 64'd0));
    send_item(make_beat(KIND_DIV, pm, 63'd7, 64'd0, 64'd0));
    send_item(make_beat(KIND_DIV, 63'd5, 63'd0, 64'd0, 64'd0));
    drain();
    set_field(PrimeTop);
    send_item(make_beat(KIND_TOM, pm, 63'd0, 64'd0, 64'd0));
    send_item(make_beat(KIND_TOM, ones, 63'd0, 64'd0, 64'd0));
    send_item(make_beat(KIND_FROM, pm, 63'd0, 64'd0, 64'd0));
    send_item(make_beat(KIND_FROM, ones, 63'd0, 64'd0, 64'd0));
    send_item(make_beat(KIND_RATIO, 63'd0, 63'd0, 64'h8000000000000000, 64'd1));
    send_item(make_beat(KIND_RATIO, 63'd0, 63'd0, 64'h7FFFFFFFFFFFFFFF,
                        64'h8000000000000000));
    send_item(make_beat(KIND_RATIO, 63'd0, 63'd0, 64'hFFFFFFFFFFFFFFFF, 64'd3));
    send_item(make_beat(KIND_RATIO, 63'd0, 63'd0, 64'd5, 64'd0 - PrimeTop));
    send_item(make_beat(KIND_RATIO, 63'd0, 63'd0, 64'd5, 64'd0));
    send_item(make_beat(4'd9, ones, ones, 64'd0, 64'd0));
    send_item(make_beat(4'd15, ones, ones, 64'd0, 64'd0));
    drain();
  endtask

  // Receiver holds off while the sender keeps offering beats
  task automatic test_backpressure();
    bit saved;
    saved = tx_idle_on;
    tx_idle_on = 1'b0;
    hold_req = 1'b1;
    repeat (12) send_item(make_beat(KIND_ADD, pick_res(), pick_res(), 64'd0, 64'd0));
    tx_idle_on = saved;
    drain();
  endtask

  // Inconsistent and extreme register values
  task automatic test_register_extremes();
    reg_write(REG_MODULUS, 64'hFFFFFFFFFFFFFFFF);
    reg_write(REG_NEGINV, 64'hFFFFFFFFFFFFFFFF);
    reg_write(REG_RSQ, 64'd9223372036854775806);
    run_random(50);
    reg_write(REG_MODULUS, 64'd0);
    reg_write(REG_NEGINV, 64'd0);
    reg_write(REG_RSQ, 64'd0);
    run_random(25);
    reg_write(2'd3, {$urandom, $urandom});
  endtask

  // Compare each taken result against the oldest expectation
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: value %0d", out_data.value);
        fails++;
      end else begin
        want = pending_q.pop_front();
        if (out_data.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, out_data.value);
          fails++;
        end
        if (out_data.singular !== want.singular) begin
          $error("singular: expected %0b, got %0b", want.singular, out_data.singular);
          fails++;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldOff) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallCap) begin
      $display("montgomery_prime_field_alu_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_MODULUS;
    cfg_wdata = '0;
    fails = 0;
    quiet_cycles = 0;
    hold_req = 1'b0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    fld_p = {1'b0, MODULUS_RST};
    fld_ninv = NEGINV_RST;
    fld_rsq = {1'b0, RSQ_RST};
    fld_sing = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_directed();
    run_random(300);
    set_field(64'd1000000007);
    run_random(200);
    set_field(Mersenne);
    run_random(250);
    set_field(64'd65537);
    test_backpressure();
    run_random(120);
    test_register_extremes();
    set_field(Mersenne);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random(60);

    if (pending_q.size() != 0) begin
      $error("%0d expected results never arrived", pending_q.size());
      fails++;
    end
    if (fails == 0) begin
      $display("montgomery_prime_field_alu_tb: PASS");
    end else begin
      $display("montgomery_prime_field_alu_tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== montgomery_prime_field_alu.f =====
hdl/mpfa_pkg.sv
hdl/montgomery_prime_field_alu.sv
hdl/mpfa_checker.sv
bench/montgomery_prime_field_alu_tb.sv
